### design/bmte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block mask toggle emitter package
// Field widths, constants and shared types of the toggle emitter.
// ----------------------------------------------------------------------------
package bmte_pkg;

   localparam int CH_W   = 2;
   localparam int ROW_W  = 4;
   localparam int MASK_W = 16;
   localparam int BLK_W  = 8;
   localparam int IDX_W  = 4;

   typedef logic [MASK_W-1:0] mask_type;

   // A row that was never written holds every enable bit set.
   localparam mask_type ALL_ONES = 16'hFFFF;

   // Hand-off of one toggle run from the controller to the emitter.
   typedef struct packed {
      logic             load;
      logic [CH_W-1:0]  channel;
      logic [BLK_W-1:0] base;
      mask_type         diff;
   } emit_load_type;

endpackage

### design/bmte_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one row mask update.
// ----------------------------------------------------------------------------
interface bmte_req_if;
   logic                        valid;
   logic                        ready;
   logic [bmte_pkg::CH_W-1:0]   channel;
   logic [bmte_pkg::ROW_W-1:0]  row;
   logic [bmte_pkg::MASK_W-1:0] new_mask;

   modport source (output valid, output channel, output row, output new_mask,
                   input ready);
   modport sink   (input valid, input channel, input row, input new_mask,
                   output ready);
endinterface

### design/bmte_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one toggle command.
// ----------------------------------------------------------------------------
interface bmte_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bmte_pkg::CH_W-1:0]  out_channel;
   logic [bmte_pkg::BLK_W-1:0] block_number;
   logic                       last;

   modport source (output valid, output out_channel, output block_number,
                   output last, input ready);
   modport sink   (input valid, input out_channel, input block_number,
                   input last, output ready);
endinterface

### design/bmte_shadow_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow mask memory
// One write port and one read port with registered read data. A valid bit per
// entry makes rows that were never written read as all ones.
// ----------------------------------------------------------------------------
module bmte_shadow_mem #(
   parameter int DEPTH = 48,
   parameter int AW    = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output bmte_pkg::mask_type rd_data,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  bmte_pkg::mask_type wr_data
);

   bmte_pkg::mask_type shadow_ff [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   bmte_pkg::mask_type rd_data_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         shadow_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= shadow_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : bmte_pkg::ALL_ONES;

endmodule

### design/bmte_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toggle emitter
// Walks the differing bits of one row from the lowest up and sends one toggle
// command per bit through an output register.
// ----------------------------------------------------------------------------
module bmte_emitter (
   input  logic                    clock,
   input  logic                    reset,
   input  bmte_pkg::emit_load_type load,
   output logic                    busy,
   bmte_rsp_if.source              rsp
);

   bmte_pkg::mask_type              diff_ff;
   logic [bmte_pkg::CH_W-1:0]       ch_ff;
   logic [bmte_pkg::BLK_W-1:0]      base_ff;
   logic                            rsp_valid_ff;
   logic [bmte_pkg::CH_W-1:0]       rsp_ch_ff;
   logic [bmte_pkg::BLK_W-1:0]      rsp_blk_ff;
   logic                            rsp_last_ff;

   logic [bmte_pkg::IDX_W-1:0]      idx_in;
   bmte_pkg::mask_type              rest_in;
   logic                            emit;

   // Lowest set bit of the remaining difference.
   always_comb begin
      idx_in = '0;
      for (int i = bmte_pkg::MASK_W - 1; i >= 0; i--) begin
         if (diff_ff[i]) begin
            idx_in = bmte_pkg::IDX_W'(i);
         end
      end
   end

   assign rest_in = diff_ff & (diff_ff - bmte_pkg::MASK_W'(1));
   assign busy    = (diff_ff != '0);
   assign emit    = busy && (!rsp_valid_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load.load) begin
            diff_ff <= load.diff;
         end else if (emit) begin
            diff_ff <= rest_in;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load.load) begin
         ch_ff   <= load.channel;
         base_ff <= load.base;
      end
      if (emit) begin
         rsp_ch_ff   <= ch_ff;
         rsp_blk_ff  <= base_ff + {{(bmte_pkg::BLK_W - bmte_pkg::IDX_W){1'b0}}, idx_in};
         rsp_last_ff <= (rest_in == '0);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_channel  = rsp_ch_ff;
   assign rsp.block_number = rsp_blk_ff;
   assign rsp.last         = rsp_last_ff;

endmodule

### design/block_mask_toggle_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block mask toggle emitter
// Keeps a shadow of per-channel block enable rows and turns each row update
// into toggle commands for the bits that changed.
// ----------------------------------------------------------------------------
// Usage:
//   req carries a channel, a row and the new 16-bit row mask. rsp returns one
//   transaction per changed column, lowest column first, with the flat block
//   number row*COLUMNS+column; last marks the final command of the run.
//   An unchanged row, or a channel or row out of range, gives no command.
//   Timing: a request is looked up in the shadow memory in ST_LOOKUP, the
//   run is loaded into the emitter at the edge that ends the lookup and the
//   first command then passes from the emitter's difference register to
//   the output register. The emitter sends one command per cycle while
//   rsp.ready does not stall it; req.ready returns once the emitter has
//   handed its last command to the output register.
//   Reset empties the output and marks every shadow row as all ones at once.
//   When rsp.ready is low the output register holds its command and the
//   emitter, and then req.ready, wait.
// ----------------------------------------------------------------------------
module block_mask_toggle_emitter #(
   parameter int CHANNELS = 4,
   parameter int ROWS     = 12,
   parameter int COLUMNS  = 16
) (
   input  logic       clock,
   input  logic       reset,
   bmte_req_if.sink   req,
   bmte_rsp_if.source rsp
);

   localparam int DEPTH = CHANNELS * ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam bmte_pkg::mask_type COL_MASK = 16'((33'd1 << COLUMNS) - 33'd1);

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type                   state_ff;
   logic [bmte_pkg::CH_W-1:0]   ch_ff;
   logic [bmte_pkg::BLK_W-1:0]  base_ff;
   bmte_pkg::mask_type          mask_ff;
   logic [AW-1:0]               addr_ff;

   logic                        accept;
   logic                        in_range;
   logic                        rd_en;
   logic [AW-1:0]               req_addr;
   bmte_pkg::mask_type          rd_data;
   bmte_pkg::mask_type          diff;
   logic                        busy;
   bmte_pkg::emit_load_type     load;

   assign req.ready = (state_ff == ST_IDLE) && !busy;
   assign accept    = req.valid && req.ready;
   assign in_range  = (32'(req.channel) < 32'(CHANNELS)) && (32'(req.row) < 32'(ROWS));
   assign rd_en     = accept && in_range;
   assign req_addr  = AW'(32'(req.channel) * 32'(ROWS) + 32'(req.row));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (rd_en) begin
                  ch_ff    <= req.channel;
                  base_ff  <= bmte_pkg::BLK_W'(32'(req.row) * 32'(COLUMNS));
                  mask_ff  <= req.new_mask;
                  addr_ff  <= req_addr;
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // The stored row arrives during the lookup cycle; the new mask is written
   // back at the same edge that hands the difference to the emitter.
   assign diff         = (mask_ff ^ rd_data) & COL_MASK;
   assign load.load    = (state_ff == ST_LOOKUP) && (diff != '0);
   assign load.channel = ch_ff;
   assign load.base    = base_ff;
   assign load.diff    = diff;

   bmte_shadow_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (req_addr),
      .rd_data (rd_data),
      .wr_en   (state_ff == ST_LOOKUP),
      .wr_addr (addr_ff),
      .wr_data (mask_ff)
   );

   bmte_emitter u_emitter (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .busy  (busy),
      .rsp   (rsp)
   );

endmodule

### tb/sv/bmte_toggle_tracker_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toggle tracker
// Mirrors the shadow row masks of the toggle emitter, predicts the toggle
// commands that each accepted row update must produce and checks the
// commands that come back against them in order.
// ----------------------------------------------------------------------------
package bmte_toggle_tracker_pkg;

   import bmte_pkg::*;

   localparam int NUM_CHANNELS = 4;
   localparam int NUM_ROWS     = 12;
   localparam int NUM_COLUMNS  = 16;

   typedef struct packed {
      logic [CH_W-1:0]  channel;
      logic [BLK_W-1:0] block;
      logic             last;
   } toggle_cmd_type;

   class block_toggle_tracker;

      mask_type       shadow_rows[NUM_CHANNELS][NUM_ROWS];
      toggle_cmd_type expected_toggles[$];
      int unsigned    errors;

      function new();
         foreach (shadow_rows[c, r]) shadow_rows[c][r] = ALL_ONES;
         errors = 0;
      endfunction

      task report(input string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function int unsigned pending_count();
         return expected_toggles.size();
      endfunction

      // One accepted row update: one toggle per changed column, lowest first.
      function void note_update(input logic [CH_W-1:0] ch, input logic [ROW_W-1:0] row,
                                input mask_type mask);
         mask_type       diff;
         toggle_cmd_type cmd;
         int             b;
         if (ch >= NUM_CHANNELS || row >= NUM_ROWS) return;
         diff = mask ^ shadow_rows[ch][row];
         for (b = 0; b < NUM_COLUMNS; b++) begin
            if (diff[b]) begin
               cmd.channel = ch;
               cmd.block   = BLK_W'(int'(row) * NUM_COLUMNS + b);
               // The last command is the one with no changed column above it.
               cmd.last    = ((diff >> (b + 1)) == '0);
               expected_toggles.push_back(cmd);
            end
         end
         shadow_rows[ch][row] = mask;
      endfunction

      task check_toggle(input logic [CH_W-1:0] ch, input logic [BLK_W-1:0] block,
                        input logic last);
         toggle_cmd_type exp;
         if (expected_toggles.size() == 0) begin
            report($sformatf("unexpected toggle channel %0d block %0d last %b",
                             ch, block, last));
            return;
         end
         exp = expected_toggles.pop_front();
         if (ch !== exp.channel)
            report($sformatf("channel %0d, expected %0d (block %0d)", ch, exp.channel,
                             exp.block));
         if (block !== exp.block)
            report($sformatf("block %0d, expected %0d", block, exp.block));
         if (last !== exp.last)
            report($sformatf("last %b, expected %b (block %0d)", last, exp.last,
                             exp.block));
      endtask

      task check_drained();
         toggle_cmd_type exp;
         while (expected_toggles.size() != 0) begin
            exp = expected_toggles.pop_front();
            report($sformatf("missing toggle channel %0d block %0d last %b",
                             exp.channel, exp.block, exp.last));
         end
      endtask

   endclass

endpackage

### tb/sv/block_mask_toggle_emitter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block mask toggle emitter test
// Drives row mask updates into the emitter in random bursts while the
// response side stalls on its own pattern, and checks every toggle command
// against a predicted shadow of the block grid. A directed opening covers
// unchanged rows, full and single-column changes, the grid corners and
// rows out of range, then mostly shadow-aware random updates follow.
// ----------------------------------------------------------------------------
module block_mask_toggle_emitter_test;

   import bmte_pkg::*;
   import bmte_toggle_tracker_pkg::*;

   localparam int RANDOM_UPDATES = 100;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int DRAIN_CYCLES   = 40;

   logic clock;
   logic reset;

   bmte_req_if req_bus();
   bmte_rsp_if rsp_bus();

   block_toggle_tracker tracker = new();

   // Masks last accepted per row, used only to aim the random updates.
   mask_type sent_rows[NUM_CHANNELS][NUM_ROWS];

   int unsigned stall_mode;
   int unsigned stall_left;

   block_mask_toggle_emitter #(
      .CHANNELS (NUM_CHANNELS),
      .ROWS     (NUM_ROWS),
      .COLUMNS  (NUM_COLUMNS)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("block_mask_toggle_emitter_test: errors");
      $finish;
   end

   // Response side: stretches of full readiness, random readiness and stalls.
   always @(posedge clock) begin
      if (reset) begin
         stall_mode    <= 0;
         stall_left    <= 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(1, 12);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            default: rsp_bus.ready <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            tracker.check_toggle(rsp_bus.out_channel, rsp_bus.block_number, rsp_bus.last);
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            tracker.note_update(req_bus.channel, req_bus.row, req_bus.new_mask);
      end
   end

   // Holds the update on the bus until the transaction completes.
   task automatic send_update(input logic [CH_W-1:0] ch, input logic [ROW_W-1:0] row,
                              input mask_type mask);
      req_bus.valid    <= 1'b1;
      req_bus.channel  <= ch;
      req_bus.row      <= row;
      req_bus.new_mask <= mask;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (row < NUM_ROWS) sent_rows[ch][row] = mask;
   endtask

   task automatic pause_updates(input int unsigned cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      int unsigned      counted;
      int unsigned      burst_left;
      logic [CH_W-1:0]  ch;
      logic [ROW_W-1:0] row;
      mask_type         mask;

      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.channel  <= '0;
      req_bus.row      <= '0;
      req_bus.new_mask <= '0;
      foreach (sent_rows[c, r]) sent_rows[c][r] = ALL_ONES;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening. Rows start as all ones, so rewriting that is silent.
      send_update(2'd0, 4'd0,  16'hFFFF);
      send_update(2'd0, 4'd0,  16'h0000);
      send_update(2'd0, 4'd0,  16'hFFFF);
      send_update(2'd3, 4'd11, 16'h7FFF);
      send_update(2'd3, 4'd11, 16'hFFFE);
      send_update(2'd1, 4'd5,  16'hAAAA);
      pause_updates(3);
      send_update(2'd1, 4'd5,  16'h5555);
      send_update(2'd1, 4'd5,  16'h5555);
      send_update(2'd2, 4'd12, 16'h0000);
      send_update(2'd2, 4'd15, 16'h0000);
      send_update(2'd3, 4'd15, 16'h1234);
      send_update(2'd2, 4'd0,  16'h0000);
      send_update(2'd2, 4'd8,  16'hFFFF);
      send_update(2'd0, 4'd1,  16'hFFFE);
      send_update(2'd3, 4'd7,  16'h8000);
      send_update(2'd3, 4'd7,  16'h0001);
      send_update(2'd1, 4'd10, 16'h00FF);
      send_update(2'd2, 4'd11, 16'h0000);
      pause_updates(1);

      counted    = 0;
      burst_left = $urandom_range(1, 12);
      while (counted < RANDOM_UPDATES) begin
         ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
         if ($urandom_range(0, 9) == 0) begin
            // Rows beyond the grid are dropped by the block.
            row  = ROW_W'($urandom_range(NUM_ROWS, 15));
            mask = mask_type'($urandom);
         end else begin
            row = ROW_W'($urandom_range(0, NUM_ROWS - 1));
            case ($urandom_range(0, 6))
               0, 1: mask = mask_type'($urandom);
               2: mask = sent_rows[ch][row] ^ (mask_type'(1) << $urandom_range(0, 15));
               3: mask = sent_rows[ch][row] ^ mask_type'($urandom & $urandom);
               4: mask = sent_rows[ch][row];
               5: mask = ~sent_rows[ch][row];
               default: mask = $urandom_range(0, 1) ? ALL_ONES : '0;
            endcase
            counted++;
         end
         send_update(ch, row, mask);
         if (burst_left == 0) begin
            pause_updates($urandom_range(1, 8));
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
      pause_updates(1);

      while (tracker.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      tracker.check_drained();
      if (tracker.errors == 0)
         $display("block_mask_toggle_emitter_test: clean");
      else
         $display("block_mask_toggle_emitter_test: errors");
      $finish;
   end

endmodule
